### rtl/alaf_pkg.sv
`default_nettype none

package alaf_pkg;

  // Q16 representation of one
  localparam logic [16:0] Q16_ONE = 17'h10000;

  // Configuration register indexes
  localparam logic [1:0] REG_FILTER_CONSTANT = 2'd0;
  localparam logic [1:0] REG_INV_MIN_STEP    = 2'd1;
  localparam logic [1:0] REG_INV_ATTEN       = 2'd2;

  // Reset values of the configuration registers
  localparam logic [16:0] FC_RESET  = 17'd32768;
  localparam logic [15:0] IMS_RESET = 16'd50;
  localparam logic [16:0] IA_RESET  = 17'd21845;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_ALPHA,
    ST_BLEND,
    ST_DONE
  } alaf_state_e;

endpackage

`default_nettype wire

### rtl/adaptive_lowpass_accel_filter.sv
`default_nettype none

// Adaptive low-pass filter for a three-axis accelerometer. Each sample transfer
// blends the new vector into the held filtered vector and returns the updated
// vector as one result transfer. The blend weight is the base filter constant
// when the integer magnitude of the vector moves by a clear step, otherwise the
// constant scaled by the attenuation reciprocal (all weights unsigned Q16, and
// values above one saturate to one). A single 18x18 multiplier is reused for
// the six squares, the weight product and the three axis blends, and one
// bit-per-cycle root unit runs twice, for the held and the new magnitude. The
// input is not ready while an item is in progress; the result sits in its own
// register, so the last step waits only if that register is still occupied.
module adaptive_lowpass_accel_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_wdata_i,
  // Sample stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // sample_x, sample_y, sample_z
  // Filtered stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o   // filtered_x, filtered_y, filtered_z
);
  import alaf_pkg::*;

  // Configuration registers
  logic [16:0] fc_q;
  logic [15:0] ims_q;
  logic [16:0] ia_q;

  // Datapath state
  alaf_state_e        state_q, state_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               phase_q, phase_d;
  logic [31:0]        sum_q, sum_d;
  logic [16:0]        acc_q, acc_d;
  logic [15:0]        mag_old_q, mag_old_d;
  logic [16:0]        alpha_q, alpha_d;
  logic signed [15:0] held_q [3];
  logic signed [15:0] sample_q [3];
  logic [47:0]        out_q;
  logic               out_vld_q;

  // Combinational helpers
  logic               accept;
  logic               load_out;
  logic               held_we;
  logic [1:0]         idx;
  logic signed [15:0] sel_val;
  logic signed [16:0] sel_ext;
  logic [16:0]        sel_abs;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic [33:0]        trial;
  logic               fits;
  logic [16:0]        fc_sat, ia_sat;
  logic [15:0]        mag_new;
  logic [15:0]        mag_diff;
  logic               big;
  logic signed [16:0] blend_diff;
  logic signed [35:0] blend_acc;
  logic signed [19:0] blend_q16;
  logic signed [19:0] blend_res;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign load_out = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  // Saturate weights above one
  assign fc_sat = (fc_q > Q16_ONE) ? Q16_ONE : fc_q;
  assign ia_sat = (ia_q > Q16_ONE) ? Q16_ONE : ia_q;

  // Axis selection for squares and blends
  assign idx     = cnt_q[1:0];
  assign sel_val = (phase_q && state_q == ST_SQ) ? sample_q[idx] : held_q[idx];
  assign sel_ext = {sel_val[15], sel_val};
  assign sel_abs = sel_ext[16] ? 17'(-sel_ext) : 17'(sel_ext);

  // Root unit: one result bit per cycle
  assign trial = ({17'b0, acc_q} + (34'd1 << cnt_q)) << cnt_q;
  assign fits  = ({2'b0, sum_q} >= trial);

  // Step decision
  assign mag_new  = acc_q[16:1];
  assign mag_diff = (mag_old_q > mag_new) ? (mag_old_q - mag_new) : (mag_new - mag_old_q);
  assign big      = (mag_diff != 16'd0) && (ims_q != 16'd0) &&
                    ((mag_diff > 16'd1) || (ims_q > 16'd1));

  // Blend: held*2^16 + (sample - held)*alpha, truncated toward zero
  assign blend_diff = {sample_q[idx][15], sample_q[idx]} - {held_q[idx][15], held_q[idx]};
  assign blend_acc  = {{4{held_q[idx][15]}}, held_q[idx], 16'b0} + prod;
  assign blend_q16  = blend_acc[35:16];
  assign blend_res  = (blend_acc[35] && (blend_acc[15:0] != 16'd0)) ?
                      (blend_q16 + 20'sd1) : blend_q16;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = {1'b0, sel_abs};
        mul_b = {1'b0, sel_abs};
      end
      ST_ALPHA: begin
        mul_a = {1'b0, fc_sat};
        mul_b = {1'b0, ia_sat};
      end
      ST_BLEND: begin
        mul_a = {blend_diff[16], blend_diff};
        mul_b = {1'b0, alpha_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    sum_d     = sum_q;
    acc_d     = acc_q;
    mag_old_d = mag_old_q;
    alpha_d   = alpha_q;
    held_we   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = 4'd0;
          phase_d = 1'b0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        sum_d = ((cnt_q == 4'd0) ? 32'd0 : sum_q) + prod[31:0];
        if (cnt_q == 4'd2) begin
          cnt_d   = 4'd15;
          acc_d   = 17'd0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_ROOT: begin
        if (fits) begin
          sum_d = sum_q - trial[31:0];
          acc_d = acc_q | (17'd2 << cnt_q);
        end
        if (cnt_q == 4'd0) begin
          if (!phase_q) begin
            mag_old_d = acc_d[16:1];
            phase_d   = 1'b1;
            state_d   = ST_SQ;
          end else begin
            state_d = ST_ALPHA;
          end
        end else begin
          cnt_d = cnt_q - 4'd1;
        end
      end
      ST_ALPHA: begin
        alpha_d = big ? fc_sat : prod[32:16];
        cnt_d   = 4'd0;
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        held_we = 1'b1;
        if (cnt_q == 4'd2) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= 4'd0;
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
      fc_q      <= FC_RESET;
      ims_q     <= IMS_RESET;
      ia_q      <= IA_RESET;
      held_q[0] <= '0;
      held_q[1] <= '0;
      held_q[2] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FILTER_CONSTANT: fc_q  <= cfg_wdata_i;
          REG_INV_MIN_STEP:    ims_q <= cfg_wdata_i[15:0];
          REG_INV_ATTEN:       ia_q  <= cfg_wdata_i;
          default:             ;
        endcase
      end
      if (held_we) begin
        held_q[idx] <= blend_res[15:0];
      end
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    acc_q     <= acc_d;
    mag_old_q <= mag_old_d;
    alpha_q   <= alpha_d;
    if (accept) begin
      sample_q[0] <= s_axis_tdata_i[15:0];
      sample_q[1] <= s_axis_tdata_i[31:16];
      sample_q[2] <= s_axis_tdata_i[47:32];
    end
    if (load_out) begin
      out_q <= {held_q[2], held_q[1], held_q[0]};
    end
  end

  // Weight never exceeds one during a blend
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND) |-> (alpha_q <= Q16_ONE))
    else $error("blend weight above one");

  // Squares run over three axes only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> (cnt_q <= 4'd2))
    else $error("square counter out of range");

  // A new result comes only from the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside final step");

  // A fresh result matches the held vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      (m_axis_tdata_o == {held_q[2], held_q[1], held_q[0]}))
    else $error("result differs from held vector");

endmodule

`default_nettype wire
